/* sv/b2r_pkg.sv */
// ----------------------------------------------------------------------------
// b2r_pkg
// Shared types, constants and lookup functions for the roman numeral converter.
// ----------------------------------------------------------------------------
package b2r_pkg;

	localparam int NUM_W     = 12;
	localparam int REM_W     = 10;  // remainder below one thousand
	localparam int REM2_W    = 7;   // remainder below one hundred
	localparam int LETTER_W  = 7;
	localparam int S_DATA_W  = 16;
	localparam int M_DATA_W  = 8;
	localparam int MAX_VALID = 3999;
	localparam int THOUSAND  = 1000;
	localparam int HUNDRED   = 100;
	localparam int TEN       = 10;

	// command queue, depth must be a power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	// ascii letters
	localparam logic [LETTER_W-1:0] CH_NONE = 7'h00;
	localparam logic [LETTER_W-1:0] CH_I    = 7'h49;
	localparam logic [LETTER_W-1:0] CH_V    = 7'h56;
	localparam logic [LETTER_W-1:0] CH_X    = 7'h58;
	localparam logic [LETTER_W-1:0] CH_L    = 7'h4C;
	localparam logic [LETTER_W-1:0] CH_C    = 7'h43;
	localparam logic [LETTER_W-1:0] CH_D    = 7'h44;
	localparam logic [LETTER_W-1:0] CH_M    = 7'h4D;

	// decimal places, most significant first
	typedef enum logic [1:0] {
		PL_THOU = 2'd0,
		PL_HUND = 2'd1,
		PL_TENS = 2'd2,
		PL_ONES = 2'd3
	} place_t;

	// symbol roles inside one place
	typedef enum logic [1:0] {
		SYM_UNIT = 2'd0,
		SYM_FIVE = 2'd1,
		SYM_NEXT = 2'd2
	} sym_t;

	// one classified number, digits indexed by place
	typedef struct packed {
		logic             err;
		logic [3:0][3:0]  dig;
	} cmd_t;

	// letters produced by one decimal digit
	function automatic logic [2:0] digit_len(input logic [3:0] d);
		logic [2:0] n;
		unique case (d)
			4'd0:    n = 3'd0;
			4'd1:    n = 3'd1;
			4'd2:    n = 3'd2;
			4'd3:    n = 3'd3;
			4'd4:    n = 3'd2;
			4'd5:    n = 3'd1;
			4'd6:    n = 3'd2;
			4'd7:    n = 3'd3;
			4'd8:    n = 3'd4;
			4'd9:    n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// symbol role of letter pos of digit d
	function automatic sym_t digit_sym(input logic [3:0] d, input logic [1:0] pos);
		sym_t s;
		s = SYM_UNIT;
		unique case (d)
			4'd4:                      s = (pos == 2'd1) ? SYM_FIVE : SYM_UNIT;
			4'd5, 4'd6, 4'd7, 4'd8:    s = (pos == 2'd0) ? SYM_FIVE : SYM_UNIT;
			4'd9:                      s = (pos == 2'd1) ? SYM_NEXT : SYM_UNIT;
			default:                   s = SYM_UNIT;
		endcase
		return s;
	endfunction

	function automatic logic [LETTER_W-1:0] place_letter(input place_t p, input sym_t s);
		logic [LETTER_W-1:0] ch;
		ch = CH_NONE;
		unique case (p)
			PL_THOU: ch = CH_M;
			PL_HUND: ch = (s == SYM_UNIT) ? CH_C : (s == SYM_FIVE) ? CH_D : CH_M;
			PL_TENS: ch = (s == SYM_UNIT) ? CH_X : (s == SYM_FIVE) ? CH_L : CH_C;
			PL_ONES: ch = (s == SYM_UNIT) ? CH_I : (s == SYM_FIVE) ? CH_V : CH_X;
			default: ch = CH_NONE;
		endcase
		return ch;
	endfunction

endpackage

/* sv/b2r_front.sv */
// ----------------------------------------------------------------------------
// b2r_front
// Accepts numbers, checks range and splits them into decimal digits.
// ----------------------------------------------------------------------------
module b2r_front import b2r_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [NUM_W-1:0] number,
	output logic             push_valid,
	input  logic             push_ready,
	output cmd_t             push_cmd
);

	logic             valid_s1;
	logic             err_s1;
	logic [3:0]       thou_s1;
	logic [REM_W-1:0] rem_s1;

	logic [3:0]        thou_d;
	logic [REM_W-1:0]  rem_d;
	logic [REM_W-1:0]  sub_t;
	logic [3:0]        hund;
	logic [REM_W-1:0]  sub_h;
	logic [REM2_W-1:0] rem2;
	logic [3:0]        tens;
	logic [REM2_W-1:0] sub_e;
	logic [3:0]        ones;
	logic              take;

	assign in_ready = !valid_s1 || push_ready;
	assign take     = in_valid && in_ready;

	// thousands by compare against constant multiples
	always_comb begin
		thou_d = 4'd0;
		sub_t  = '0;
		for (int k = 1; k <= 3; k++) begin
			if (number >= NUM_W'(k * THOUSAND)) begin
				thou_d = 4'(k);
				sub_t  = REM_W'(k * THOUSAND % (1 << REM_W));
			end
		end
		rem_d = REM_W'(number) - sub_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			err_s1  <= (number == '0) || (number > NUM_W'(MAX_VALID));
			thou_s1 <= thou_d;
			rem_s1  <= rem_d;
		end
	end

	// hundreds, tens and ones from the registered remainder
	always_comb begin
		hund  = 4'd0;
		sub_h = '0;
		for (int k = 1; k <= 9; k++) begin
			if (rem_s1 >= REM_W'(k * HUNDRED)) begin
				hund  = 4'(k);
				sub_h = REM_W'(k * HUNDRED);
			end
		end
		rem2  = REM2_W'(rem_s1 - sub_h);
		tens  = 4'd0;
		sub_e = '0;
		for (int k = 1; k <= 9; k++) begin
			if (rem2 >= REM2_W'(k * TEN)) begin
				tens  = 4'(k);
				sub_e = REM2_W'(k * TEN);
			end
		end
		ones = 4'(rem2 - sub_e);
	end

	assign push_valid             = valid_s1;
	assign push_cmd.err           = err_s1;
	assign push_cmd.dig[PL_THOU]  = thou_s1;
	assign push_cmd.dig[PL_HUND]  = hund;
	assign push_cmd.dig[PL_TENS]  = tens;
	assign push_cmd.dig[PL_ONES]  = ones;

endmodule

/* sv/b2r_queue.sv */
// ----------------------------------------------------------------------------
// b2r_queue
// Short command queue between the digit splitter and the letter generator.
// ----------------------------------------------------------------------------
module b2r_queue import b2r_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = cnt_q != QCNT_W'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* sv/b2r_back.sv */
// ----------------------------------------------------------------------------
// b2r_back
// Walks the queued digits and emits one numeral letter per cycle while a
// command is queued and the output is not stalled.
module b2r_back import b2r_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  cmd_t                pop_cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [LETTER_W-1:0] letter,
	output logic                last,
	output logic                error
);

	logic                start_q;   // head entry not yet started
	place_t              place_q;
	logic [1:0]          pos_q;
	logic                out_valid_q;
	logic [LETTER_W-1:0] letter_q;
	logic                last_q;
	logic                error_q;

	place_t              first_pl;
	place_t              next_pl;
	place_t              cur_pl;
	logic                rest_nz;
	logic [3:0]          dig;
	logic [2:0]          len;
	logic                digit_end;
	logic                is_last;
	logic [LETTER_W-1:0] ch;
	logic                fire;

	always_comb begin
		first_pl = PL_ONES;
		for (int k = 3; k >= 0; k--) begin
			if (pop_cmd.dig[k] != 4'd0) begin
				first_pl = place_t'(2'(k));
			end
		end
		cur_pl  = start_q ? first_pl : place_q;
		next_pl = PL_ONES;
		rest_nz = 1'b0;
		for (int k = 3; k >= 0; k--) begin
			if (2'(k) > cur_pl && pop_cmd.dig[k] != 4'd0) begin
				next_pl = place_t'(2'(k));
				rest_nz = 1'b1;
			end
		end
		dig       = pop_cmd.dig[cur_pl];
		len       = digit_len(dig);
		digit_end = {1'b0, pos_q} == len - 3'd1;
		is_last   = pop_cmd.err || (digit_end && !rest_nz);
		ch        = pop_cmd.err ? CH_NONE : place_letter(cur_pl, digit_sym(dig, pos_q));
	end

	assign fire      = pop_valid && (!out_valid_q || out_ready);
	assign pop_ready = fire && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= 1'b1;
			place_q     <= PL_THOU;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire || out_ready) begin
				out_valid_q <= fire;
			end
			if (fire) begin
				if (is_last) begin
					start_q <= 1'b1;
					pos_q   <= '0;
				end else if (digit_end) begin
					start_q <= 1'b0;
					place_q <= next_pl;
					pos_q   <= '0;
				end else begin
					start_q <= 1'b0;
					place_q <= cur_pl;
					pos_q   <= pos_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			letter_q <= ch;
			last_q   <= is_last;
			error_q  <= pop_cmd.err;
		end
	end

	assign out_valid = out_valid_q;
	assign letter    = letter_q;
	assign last      = last_q;
	assign error     = error_q;

endmodule

/* sv/binary_to_roman_numeral.sv */
// ----------------------------------------------------------------------------
// binary_to_roman_numeral
// Converts a binary number to its roman numeral as a run of ascii letters.
// ----------------------------------------------------------------------------
// usage
//   s_* channel takes one 12-bit number per word in s_tdata[11:0]
//   m_* channel returns the numeral one letter per word, most significant
//   first, in m_tdata[6:0]; m_tlast marks the final letter of a number
//   m_tuser is the error flag: 0 or above 3999 gives a single word with
//   letter 0, m_tlast and m_tuser high
//   path: a number passes the digit register, the command queue and the
//   output register; throughput: one letter per cycle while not stalled,
//   a numeral has 1 to 15 letters; the letter walker sets that rate, the
//   digit splitter accepts a number every cycle while the queue has room
//   a four-entry command queue sits between splitter and walker, so input
//   keeps flowing while the output side is stalled until the queue fills
//   m_tready low holds the current word; reset empties queue and output
// ----------------------------------------------------------------------------
module binary_to_roman_numeral import b2r_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // [11:0] number, [15:12] zero
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // [6:0] letter, [7] zero
	output logic                m_tlast,
	output logic                m_tuser    // [0] error
);

	// splitter to queue
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;

	// queue to letter walker
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	logic [LETTER_W-1:0] letter;

	// front: range check and decimal digit split
	b2r_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.number     (s_tdata[NUM_W-1:0]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// decouples the two sides
	b2r_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// back: one letter per cycle into the output register unless stalled
	b2r_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.letter    (letter),
		.last      (m_tlast),
		.error     (m_tuser)
	);

	assign m_tdata = {{(M_DATA_W - LETTER_W){1'b0}}, letter};

	// error word is a lone zero letter
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata[6:0] == CH_NONE)
		else $error("error word without last or with a letter");

	// only an error word carries a non-numeral letter
	a_letter_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[6:0] == CH_I || m_tdata[6:0] == CH_V ||
			m_tdata[6:0] == CH_X || m_tdata[6:0] == CH_L || m_tdata[6:0] == CH_C ||
			m_tdata[6:0] == CH_D || m_tdata[6:0] == CH_M)
		else $error("valid numeral word carries a non-numeral letter");

	// a word inside a numeral never carries the error flag
	a_mid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !m_tuser)
		else $error("error flag on a non-final letter");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_to_roman_numeral. A table of directed
// numbers goes in first, then a random mix of valid and out-of-range values.
// Each accepted number is turned into its expected run of letters, and every
// output word is compared in order against that run. Both stream sides
// stall at random, with one stretch where neither side stalls.
// ----------------------------------------------------------------------------
module tb;
	import b2r_pkg::*;

	// one expected output word
	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                last;
		logic                error;
	} numeral_word_t;

	// how a directed row gets its expected letters
	typedef enum logic [1:0] {
		BY_PREDICTOR,
		BY_TEXT,
		BY_ERROR
	} check_kind_t;

	typedef struct {
		logic [NUM_W-1:0] number;
		check_kind_t      kind;
		string            text;
	} directed_row_t;

	localparam int N_DIRECTED = 24;
	localparam int N_RANDOM   = 96;
	localparam int IDLE_PCT   = 36;
	localparam int DRAIN_CYC  = 20;

	// digit patterns for every place, error cases and the longest numeral
	directed_row_t directed_rows [N_DIRECTED] = '{
		'{12'd0,    BY_ERROR,     ""},
		'{12'd4000, BY_ERROR,     ""},
		'{12'd4095, BY_ERROR,     ""},
		'{12'd1,    BY_TEXT,      "I"},
		'{12'd3999, BY_TEXT,      "MMMCMXCIX"},
		'{12'd3888, BY_TEXT,      "MMMDCCCLXXXVIII"},
		'{12'd3,    BY_TEXT,      "III"},
		'{12'd4,    BY_TEXT,      "IV"},
		'{12'd5,    BY_TEXT,      "V"},
		'{12'd9,    BY_TEXT,      "IX"},
		'{12'd10,   BY_TEXT,      "X"},
		'{12'd40,   BY_TEXT,      "XL"},
		'{12'd90,   BY_TEXT,      "XC"},
		'{12'd400,  BY_TEXT,      "CD"},
		'{12'd900,  BY_TEXT,      "CM"},
		'{12'd1000, BY_TEXT,      "M"},
		'{12'd3000, BY_TEXT,      "MMM"},
		'{12'd2048, BY_PREDICTOR, ""},
		'{12'd1666, BY_PREDICTOR, ""},
		'{12'd2372, BY_PREDICTOR, ""},
		'{12'd1994, BY_PREDICTOR, ""},
		'{12'd444,  BY_PREDICTOR, ""},
		'{12'd1365, BY_PREDICTOR, ""},
		'{12'd2730, BY_PREDICTOR, ""}
	};

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;   // [11:0] number, [15:12] zero
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;         // [6:0] letter, [7] zero
	logic                m_tlast;
	logic                m_tuser;         // [0] error

	// letters still owed by the block, oldest first
	numeral_word_t numeral_q [$];

	// no stalls on either side while set
	logic steady = 1'b0;

	int mismatches   = 0;
	int numbers_sent = 0;
	int words_seen   = 0;
	int error_words  = 0;

	binary_to_roman_numeral dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// expected letters of one number: thousands, hundreds, tens, ones,
	// each digit in its subtractive form; out of range gives one error word
	function automatic void predict_numeral(input logic [NUM_W-1:0] number);
		int                  rest;
		int                  digit;
		int                  scale;
		logic [LETTER_W-1:0] one_ch;
		logic [LETTER_W-1:0] five_ch;
		logic [LETTER_W-1:0] ten_ch;
		logic [LETTER_W-1:0] run [$];
		if (number == 0 || number > MAX_VALID) begin
			numeral_q.push_back('{CH_NONE, 1'b1, 1'b1});
			return;
		end
		rest = number;
		for (int p = 0; p < 4; p++) begin
			case (place_t'(p))
				PL_THOU: begin
					scale = THOUSAND; one_ch = CH_M; five_ch = CH_M; ten_ch = CH_M;
				end
				PL_HUND: begin
					scale = HUNDRED; one_ch = CH_C; five_ch = CH_D; ten_ch = CH_M;
				end
				PL_TENS: begin
					scale = TEN; one_ch = CH_X; five_ch = CH_L; ten_ch = CH_C;
				end
				default: begin
					scale = 1; one_ch = CH_I; five_ch = CH_V; ten_ch = CH_X;
				end
			endcase
			digit = rest / scale;
			rest  = rest % scale;
			if (digit == 9) begin
				run.push_back(one_ch);
				run.push_back(ten_ch);
			end else if (digit == 4) begin
				run.push_back(one_ch);
				run.push_back(five_ch);
			end else begin
				if (digit >= 5) begin
					run.push_back(five_ch);
					digit = digit - 5;
				end
				for (int k = 0; k < digit; k++)
					run.push_back(one_ch);
			end
		end
		for (int i = 0; i < run.size(); i++)
			numeral_q.push_back('{run[i], i == run.size() - 1, 1'b0});
	endfunction

	// expected letters typed in as text
	function automatic void expect_text(input string text);
		logic [7:0] ch;
		for (int i = 0; i < text.len(); i++) begin
			ch = text[i];
			numeral_q.push_back('{ch[LETTER_W-1:0], i == text.len() - 1, 1'b0});
		end
	endfunction

	// offer one number, hold it until taken; idle cycles come first so that
	// valid never drops and rises within one step
	task automatic send_number(input logic [NUM_W-1:0] number);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W-NUM_W){1'b0}}, number};
		do @(posedge clk); while (!s_tready);
		numbers_sent++;
	endtask

	// random number: mostly valid, some zero, some above the valid range
	function automatic logic [NUM_W-1:0] pick_number();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		else if (r < 18)
			return NUM_W'($urandom_range(4095, MAX_VALID + 1));
		else if (r < 25)
			return NUM_W'($urandom_range(4095));
		return NUM_W'($urandom_range(MAX_VALID, 1));
	endfunction

	// output side back-pressure
	always @(posedge clk)
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

	// compare every word taken from the block with the oldest expectation
	always @(posedge clk) begin
		numeral_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (m_tuser)
				error_words++;
			if (numeral_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word, expected none, actual letter %h last %b error %b",
					$time, m_tdata[LETTER_W-1:0], m_tlast, m_tuser);
			end else begin
				want = numeral_q.pop_front();
				if (m_tdata[LETTER_W-1:0] !== want.letter || m_tlast !== want.last ||
						m_tuser !== want.error) begin
					mismatches++;
					$display("%0t: mismatch, expected letter %h last %b error %b, actual letter %h last %b error %b",
						$time, want.letter, want.last, want.error,
						m_tdata[LETTER_W-1:0], m_tlast, m_tuser);
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [NUM_W-1:0] number;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			send_number(directed_rows[i].number);
			case (directed_rows[i].kind)
				BY_ERROR: numeral_q.push_back('{CH_NONE, 1'b1, 1'b1});
				BY_TEXT:  expect_text(directed_rows[i].text);
				default:  predict_numeral(directed_rows[i].number);
			endcase
		end

		// random numbers, with a stall-free stretch in the middle
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 40)
				steady <= 1'b1;
			else if (i == 70)
				steady <= 1'b0;
			number = pick_number();
			send_number(number);
			predict_numeral(number);
		end
		s_tvalid <= 1'b0;

		// drain, then give late or extra words time to show up
		while (numeral_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("covered %0d numbers (%0d directed), %0d letter words checked, %0d error words",
			numbers_sent, N_DIRECTED, words_seen, error_words);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("timeout with %0d words outstanding", numeral_q.size());
		$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
sv/b2r_pkg.sv
sv/b2r_front.sv
sv/b2r_queue.sv
sv/b2r_back.sv
sv/binary_to_roman_numeral.sv
dv/tb.sv
